FILE: src/srf_pkg.sv
// Shared types and constants of the surrounded region fill block.
`timescale 1ns / 1ps

package srf_pkg;

  // Fixed widths of the transaction fields and the width register.
  localparam int unsigned RowW       = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned GridWidthW = 7;

  localparam logic [GridWidthW-1:0] GridWidthReset = 7'd64;

  typedef enum logic [1:0] {
    StLoad,
    StInit,
    StFill,
    StEmit
  } state_e;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic store;
    logic init;
    logic fill;
    logic shift;
  } cell_cmd_t;

endpackage

FILE: src/srf_in_if.sv
// Input channel: one grid row per transaction.
`timescale 1ns / 1ps

interface srf_in_if;
  logic                      valid;
  logic                      ready;
  logic [srf_pkg::RowW-1:0] row_cells;
  logic                      last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

FILE: src/srf_out_if.sv
// Output channel: one resulting row per transaction.
`timescale 1ns / 1ps

interface srf_out_if;
  logic                      valid;
  logic                      ready;
  logic [srf_pkg::IdxW-1:0] out_row_index;
  logic [srf_pkg::RowW-1:0] out_row_cells;
  logic                      out_last;
  logic                      overflow;

  modport source (output valid, output out_row_index, output out_row_cells,
                  output out_last, output overflow, input ready);
  modport sink   (input valid, input out_row_index, input out_row_cells,
                  input out_last, input overflow, output ready);
endinterface

FILE: src/surrounded_region_fill.sv
// Top level of the surrounded region fill block.
`timescale 1ns / 1ps

// Rows of a binary grid arrive one per transaction, top first; a 1 bit is an
// open cell and the row flagged last_row closes the grid. Each row is held in
// its own cell of a chain of MAX_ROWS cells, and every row offered while
// loading is taken at once. After the last row a set-up state seeds every cell
// with its open border cells, then fill cycles follow in which every cell grows
// its reachable set by one step towards its left, right, upper and lower
// neighbours; the fill ends with the first cycle in which no cell changes.
// The results then shift up the chain and leave one per cycle from the top
// cell while the receiver takes them. Open cells that cannot be reached are
// returned closed, as are columns at or beyond grid_width (0 reads as 1,
// values above MAX_COLS read as MAX_COLS). Rows past MAX_ROWS are dropped and
// every result of that grid carries overflow. The width register may only be
// written while no grid is in flight.
module surrounded_region_fill #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  srf_in_if.sink                               row_in_i,
  srf_out_if.source                            row_out_o,
  input  logic                                 cfg_we_i,
  input  logic [srf_pkg::GridWidthW-1:0]       cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  localparam int unsigned GW   = srf_pkg::GridWidthW;

  logic [GW-1:0]       grid_width_q;
  logic [GW-1:0]       w_eff;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] side_mask;

  srf_pkg::cell_cmd_t  cmd;
  logic [CntW-1:0]     row_count;
  logic [CntW-1:0]     emit_idx;
  logic                out_last;
  logic                overflow;
  logic                any_changed;

  logic [MAX_COLS-1:0] reach   [MAX_ROWS];
  logic [MAX_ROWS-1:0] changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= srf_pkg::GridWidthReset;
    end else if (cfg_we_i) begin
      grid_width_q <= cfg_wdata_i;
    end
  end

  // Effective width, its column mask and the two side columns of the border.
  always_comb begin
    w_eff = grid_width_q;
    if (w_eff == '0) begin
      w_eff = GW'(1);
    end
    if (w_eff > GW'(MAX_COLS)) begin
      w_eff = GW'(MAX_COLS);
    end
    for (int k = 0; k < MAX_COLS; k++) begin
      col_mask[k]  = GW'(k) < w_eff;
      side_mask[k] = (k == 0) || (GW'(k) == (w_eff - GW'(1)));
    end
  end

  srf_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (row_in_i.valid),
    .in_last_i     (row_in_i.last_row),
    .in_ready_o    (row_in_i.ready),
    .out_valid_o   (row_out_o.valid),
    .out_ready_i   (row_out_o.ready),
    .any_changed_i (any_changed),
    .cmd_o         (cmd),
    .row_count_o   (row_count),
    .emit_idx_o    (emit_idx),
    .out_last_o    (out_last),
    .overflow_o    (overflow)
  );

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_cell
    logic [MAX_COLS-1:0] up_reach;
    logic [MAX_COLS-1:0] down_reach;

    if (r == 0) begin : g_top
      assign up_reach = '0;
    end else begin : g_mid_up
      assign up_reach = reach[r-1];
    end

    if (r == MAX_ROWS - 1) begin : g_bottom
      assign down_reach = '0;
    end else begin : g_mid_down
      assign down_reach = reach[r+1];
    end

    srf_cell #(
      .ColW (MAX_COLS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .wr_en_i      (row_count == CntW'(r)),
      .wr_data_i    (row_in_i.row_cells[MAX_COLS-1:0]),
      .valid_i      (CntW'(r) < row_count),
      .border_row_i ((r == 0) || (CntW'(r) == (row_count - CntW'(1)))),
      .col_mask_i   (col_mask),
      .side_mask_i  (side_mask),
      .up_reach_i   (up_reach),
      .down_reach_i (down_reach),
      .reach_o      (reach[r]),
      .changed_o    (changed[r])
    );
  end

  assign any_changed = |changed;

  assign row_out_o.out_row_index = srf_pkg::IdxW'(emit_idx);
  assign row_out_o.out_row_cells = srf_pkg::RowW'(reach[0]);
  assign row_out_o.out_last      = out_last;
  assign row_out_o.overflow      = overflow;

endmodule

FILE: src/srf_cell.sv
// One cell of the chain: holds one grid row and its reachability row.
`timescale 1ns / 1ps

module srf_cell #(
  parameter int unsigned ColW = 64
) (
  input  logic               clk_i,
  input  srf_pkg::cell_cmd_t cmd_i,
  input  logic               wr_en_i,
  input  logic [ColW-1:0]    wr_data_i,
  input  logic               valid_i,
  input  logic               border_row_i,
  input  logic [ColW-1:0]    col_mask_i,
  input  logic [ColW-1:0]    side_mask_i,
  input  logic [ColW-1:0]    up_reach_i,
  input  logic [ColW-1:0]    down_reach_i,
  output logic [ColW-1:0]    reach_o,
  output logic               changed_o
);

  logic [ColW-1:0] grid_q;
  logic [ColW-1:0] reach_q, reach_d;
  logic [ColW-1:0] open_cells;
  logic [ColW-1:0] neigh;
  logic [ColW-1:0] grown;

  // Cells beyond the stored rows read as closed, so their reach stays empty.
  assign open_cells = grid_q & col_mask_i & {ColW{valid_i}};
  assign neigh      = (reach_q << 1) | (reach_q >> 1) | up_reach_i | down_reach_i;
  assign grown      = reach_q | (neigh & open_cells);

  always_comb begin
    reach_d = reach_q;
    if (cmd_i.init) begin
      reach_d = border_row_i ? open_cells : (open_cells & side_mask_i);
    end else if (cmd_i.fill) begin
      reach_d = grown;
    end else if (cmd_i.shift) begin
      reach_d = down_reach_i;
    end
  end

  assign changed_o = cmd_i.fill && (grown != reach_q);
  assign reach_o   = reach_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && wr_en_i) begin
      grid_q <= wr_data_i;
    end
    reach_q <= reach_d;
  end

endmodule

FILE: src/srf_ctrl.sv
// Sequencer: row loading, fill iterations and result emission.
`timescale 1ns / 1ps

module srf_ctrl #(
  parameter int unsigned MAX_ROWS = 64,
  localparam int unsigned CntW    = $clog2(MAX_ROWS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               any_changed_i,
  output srf_pkg::cell_cmd_t cmd_o,
  output logic [CntW-1:0]    row_count_o,
  output logic [CntW-1:0]    emit_idx_o,
  output logic               out_last_o,
  output logic               overflow_o
);

  srf_pkg::state_e state_q, state_d;
  logic [CntW-1:0] row_count_q, row_count_d;
  logic [CntW-1:0] emit_idx_q, emit_idx_d;
  logic            ovf_q, ovf_d;
  logic            in_fire;
  logic            out_fire;
  logic            room;
  logic            is_last_out;

  assign room        = row_count_q < CntW'(MAX_ROWS);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign is_last_out = emit_idx_q == (row_count_q - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srf_pkg::StLoad: if (in_fire && in_last_i) state_d = srf_pkg::StInit;
      srf_pkg::StInit: state_d = srf_pkg::StFill;
      srf_pkg::StFill: if (!any_changed_i) state_d = srf_pkg::StEmit;
      srf_pkg::StEmit: if (out_fire && is_last_out) state_d = srf_pkg::StLoad;
      default:         state_d = srf_pkg::StLoad;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    row_count_d = row_count_q;
    emit_idx_d  = emit_idx_q;
    ovf_d       = ovf_q;
    unique case (state_q)
      srf_pkg::StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (room) begin
            cmd_o.store = 1'b1;
            row_count_d = row_count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        emit_idx_d = '0;
      end
      srf_pkg::StInit: cmd_o.init = 1'b1;
      srf_pkg::StFill: cmd_o.fill = 1'b1;
      srf_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          emit_idx_d  = emit_idx_q + CntW'(1);
          if (is_last_out) begin
            row_count_d = '0;
            ovf_d       = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srf_pkg::StLoad;
      row_count_q <= '0;
      emit_idx_q  <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_count_q <= row_count_d;
      emit_idx_q  <= emit_idx_d;
      ovf_q       <= ovf_d;
    end
  end

  assign row_count_o = row_count_q;
  assign emit_idx_o  = emit_idx_q;
  assign out_last_o  = is_last_out;
  assign overflow_o  = ovf_q;

endmodule

FILE: bench/tb_surrounded_region_fill.sv
// Self-checking testbench for the surrounded region fill block.
`timescale 1ns / 1ps

module tb_surrounded_region_fill;

  localparam int unsigned RowW         = srf_pkg::RowW;
  localparam int unsigned IdxW         = srf_pkg::IdxW;
  localparam int unsigned GridWidthW   = srf_pkg::GridWidthW;
  localparam int unsigned MaxRows      = 64;
  localparam int unsigned MaxCols      = 64;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAfterRow = 60;
  localparam int unsigned CycleLimit   = 500000;

  typedef struct {
    logic [RowW-1:0] cells;
    logic            last;
  } grid_row_t;

  typedef struct {
    logic [IdxW-1:0] idx;
    logic [RowW-1:0] cells;
    logic            last;
    logic            ovf;
  } row_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  src_valid = 1'b0;
  logic [RowW-1:0]       src_cells = '0;
  logic                  src_last = 1'b0;
  logic                  snk_ready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [GridWidthW-1:0] cfg_wdata = '0;

  srf_in_if  row_in ();
  srf_out_if row_out ();

  assign row_in.valid     = src_valid;
  assign row_in.row_cells = src_cells;
  assign row_in.last_row  = src_last;
  assign row_out.ready    = snk_ready;

  surrounded_region_fill #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_in_i   (row_in),
    .row_out_o  (row_out),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus and the expected rows of every finished grid.
  grid_row_t   pending_rows[$];
  row_result_t expected_rows[$];

  // Mirror of the block's grid state, used to predict the filled rows.
  logic [RowW-1:0]       grid_rows[MaxRows];
  int unsigned           stored_rows = 0;
  bit                    overflow_seen = 1'b0;
  logic [GridWidthW-1:0] width_mirror = srf_pkg::GridWidthReset;

  int unsigned src_idle_pct = 36;
  int unsigned snk_idle_pct = 65;
  int unsigned rows_accepted = 0;
  int unsigned rows_queued = 0;
  int unsigned grids_queued = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_grids = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic [GridWidthW-1:0] mid_width;

  // Stores one accepted row and, when it closes the grid, works out which open
  // cells can be reached from the border and queues the resulting rows.
  task automatic take_row(input logic [RowW-1:0] cells, input logic last);
    logic [RowW-1:0] reach[MaxRows];
    logic [RowW-1:0] col_mask, border_cols, open_cells, nbr, grown;
    int unsigned     w;
    bit              changed;
    row_result_t     res;
    if (stored_rows < MaxRows) begin
      grid_rows[stored_rows] = cells;
      stored_rows++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (!last) return;

    w = width_mirror;
    if (w == 0) w = 1;
    if (w > MaxCols) w = MaxCols;
    col_mask = '1;
    col_mask = col_mask >> (RowW - w);
    border_cols = '0;
    border_cols[0] = 1'b1;
    border_cols[w-1] = 1'b1;

    for (int unsigned r = 0; r < stored_rows; r++) begin
      open_cells = grid_rows[r] & col_mask;
      if (r == 0 || r + 1 == stored_rows) reach[r] = open_cells;
      else reach[r] = open_cells & border_cols;
    end
    do begin
      changed = 1'b0;
      for (int unsigned r = 0; r < stored_rows; r++) begin
        open_cells = grid_rows[r] & col_mask;
        nbr = (reach[r] << 1) | (reach[r] >> 1);
        if (r > 0) nbr |= reach[r-1];
        if (r + 1 < stored_rows) nbr |= reach[r+1];
        grown = reach[r] | (nbr & open_cells);
        if (grown != reach[r]) begin
          reach[r] = grown;
          changed = 1'b1;
        end
      end
    end while (changed);

    for (int unsigned r = 0; r < stored_rows; r++) begin
      res.idx   = r[IdxW-1:0];
      res.cells = reach[r];
      res.last  = (r + 1 == stored_rows);
      res.ovf   = overflow_seen;
      expected_rows = {expected_rows, res};
    end
    stored_rows = 0;
    overflow_seen = 1'b0;
  endtask

  // Row driver: when the slot is free, offers the next pending row unless a random idle draw holds it back.
  always @(posedge clk_i or negedge rst_ni) begin : row_driver
    grid_row_t item;
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && row_in.ready) begin
        take_row(src_cells, src_last);
        rows_accepted <= rows_accepted + 1;
      end
      if (!src_valid || row_in.ready) begin
        if (pending_rows.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          item = pending_rows.pop_front();
          src_valid <= 1'b1;
          src_cells <= item.cells;
          src_last  <= item.last;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result side ready, with one long hold-off part way through the run so
  // that the block backs up and stops taking rows.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else if (!hold_done && rows_accepted >= HoldAfterRow) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      snk_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic report_field(input string name, input logic [RowW-1:0] want,
                              input logic [RowW-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    row_result_t want;
    if (rst_ni && row_out.valid && snk_ready) begin
      if (expected_rows.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transaction, row %0d cells %h", $time,
                 row_out.out_row_index, row_out.out_row_cells);
      end else begin
        want = expected_rows.pop_front();
        results_checked++;
        if (want.last && want.ovf) overflow_grids++;
        report_field("out_row_index", RowW'(want.idx), RowW'(row_out.out_row_index));
        report_field("out_row_cells", want.cells, row_out.out_row_cells);
        report_field("out_last", RowW'(want.last), RowW'(row_out.out_last));
        report_field("overflow", RowW'(want.ovf), RowW'(row_out.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run did not complete, %0d results still awaited", $time,
               expected_rows.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [RowW-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  task automatic add_row(input logic [RowW-1:0] cells, input logic last);
    grid_row_t item;
    item.cells = cells;
    item.last  = last;
    pending_rows = {pending_rows, item};
    rows_queued++;
    if (last) grids_queued++;
  endtask

  // Random grid in one of several textures; the walled texture keeps the
  // border mostly closed so that enclosed regions are common.
  task automatic add_random_grid(input int unsigned n, input int unsigned w);
    int unsigned     style;
    logic [RowW-1:0] cells;
    style = $urandom_range(3);
    for (int unsigned r = 0; r < n; r++) begin
      cells = rand_row();
      case (style)
        1: begin
          cells |= rand_row();
        end
        2: begin
          cells &= rand_row();
        end
        3: begin
          if (r == 0 || r + 1 == n) cells &= rand_row() & rand_row();
          else cells |= rand_row();
          if ($urandom_range(3) != 0) begin
            cells[0] = 1'b0;
            cells[w-1] = 1'b0;
          end
        end
        default: ;
      endcase
      add_row(cells, r + 1 == n);
    end
  endtask

  function automatic int unsigned pick_rows();
    if ($urandom_range(4) == 0) return $urandom_range(20, 9);
    return $urandom_range(8, 1);
  endfunction

  // Waits until every queued row has gone in and every result has come out.
  task automatic settle();
    while (pending_rows.size() != 0 || src_valid || expected_rows.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [GridWidthW-1:0] w);
    settle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    width_mirror = w;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed grids at the reset width.
    add_row('1, 1'b1);
    add_row('0, 1'b1);
    // A small enclosed run, with open cells in both edge columns below it.
    add_row('0, 1'b0);
    add_row(64'h0000_0000_0000_000E, 1'b0);
    add_row(64'h8000_0000_0000_0001, 1'b0);
    add_row('0, 1'b1);
    // A run reached from column 0, and an enclosed run of four cells further along the row below it.
    add_row('0, 1'b0);
    add_row(64'h0000_0000_0000_0007, 1'b0);
    add_row(64'h00F0_0000_0000_0004, 1'b0);
    add_row('0, 1'b1);
    add_row(rand_row(), 1'b0);
    add_row(rand_row(), 1'b1);

    write_width(7'd1);
    repeat (2) add_row('1, 1'b0);
    add_row('1, 1'b1);

    // A width of zero behaves as one column.
    write_width(7'd0);
    add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_row('1, 1'b1);

    // Widths above the column count behave as the full row.
    write_width(7'd127);
    add_row('0, 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
    add_row('0, 1'b1);

    write_width(7'd5);
    add_row('0, 1'b0);
    add_row('1, 1'b0);
    add_row('0, 1'b1);

    // One grid too tall for the store; its last row is the dropped one.
    write_width(7'd64);
    add_random_grid(MaxRows + 1, MaxCols);
    while (rows_queued < 98) add_random_grid(pick_rows(), MaxCols);

    mid_width = GridWidthW'($urandom_range(63, 2));
    write_width(mid_width);
    src_idle_pct = 65;
    snk_idle_pct = 36;
    while (rows_queued < 114) add_random_grid(pick_rows(), mid_width);

    write_width(7'd65);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (rows_queued < 130) add_random_grid(pick_rows(), MaxCols);

    settle();
    $display("Ran %0d grids from %0d rows and checked %0d result rows, %0d grids overflowed.",
             grids_queued, rows_accepted, results_checked, overflow_grids);
    $display("Widths 64, 1, 0, 127, 5, %0d and 65 were used; results were held off for %0d cycles.",
             mid_width, HoldCycles);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
